### design/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, codes and arithmetic helpers for the scope trigger capture.
// ----------------------------------------------------------------------------
package stc_pkg;

   typedef enum logic [1:0] {
      PH_ARM     = 2'd0,
      PH_SEARCH  = 2'd1,
      PH_CAPTURE = 2'd2
   } phase_type;

   localparam logic [1:0] MODE_AUTO   = 2'd0;
   localparam logic [1:0] MODE_NORMAL = 2'd1;
   localparam logic [1:0] MODE_SCAN   = 2'd2;

   // gain select codes: gain/10000 reduces to 1/40, 1/20, 1/8, 1/4, 1/2
   localparam logic [2:0] RANGE_DIV40 = 3'd0;
   localparam logic [2:0] RANGE_DIV20 = 3'd1;
   localparam logic [2:0] RANGE_DIV8  = 3'd2;
   localparam logic [2:0] RANGE_DIV4  = 3'd3;

   localparam logic [2:0] CSR_RANGE_CH0       = 3'd0;
   localparam logic [2:0] CSR_RANGE_CH1       = 3'd1;
   localparam logic [2:0] CSR_OFFSET_CH0      = 3'd2;
   localparam logic [2:0] CSR_OFFSET_CH1      = 3'd3;
   localparam logic [2:0] CSR_INVERT_MASK     = 3'd4;
   localparam logic [2:0] CSR_TRIGGER_LEVEL   = 3'd5;
   localparam logic [2:0] CSR_TRIGGER_CONTROL = 3'd6;
   localparam logic [2:0] CSR_AUTO_TIMEOUT    = 3'd7;

   localparam logic [7:0]  LEVEL_RESET   = 8'd40;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   localparam logic [26:0] DIV5_RECIP = 27'd52429;

   typedef struct packed {
      logic [1:0]  mode;
      logic        falling;
      logic [7:0]  level;
      logic [15:0] timeout;
   } trig_cfg_type;

   typedef struct packed {
      logic emit;
      logic last;
      logic forced;
   } trig_out_type;

   // exact floor(x/5) for x below 2048
   function automatic logic [10:0] div5(input logic [10:0] x);
      logic [26:0] p;
      p = 27'(x) * DIV5_RECIP;
      return 11'(p[26:18]);
   endfunction

endpackage

### design/stc_scale.sv
// ----------------------------------------------------------------------------
// stc_scale
// Scales one raw sample to a screen coordinate: offset, gain, clamp, invert.
// ----------------------------------------------------------------------------
module stc_scale (
   input  logic [11:0]        raw,
   input  logic signed [11:0] offset,
   input  logic [2:0]         range,
   input  logic               invert,
   output logic signed [10:0] trace
);

   logic [13:0]        sum;
   logic               neg;
   logic [13:0]        sum_abs;
   logic [12:0]        mag;
   logic [11:0]        quot;
   logic signed [12:0] quot_s;
   logic signed [12:0] value;
   logic signed [12:0] value_cl;
   logic signed [12:0] value_inv;
   logic signed [12:0] value_sat;

   assign sum     = {2'b00, raw} + {{2{offset[11]}}, offset};
   assign neg     = sum[13];
   assign sum_abs = neg ? (~sum + 14'd1) : sum;
   assign mag     = sum_abs[12:0];

   always_comb begin
      unique case (range)
         stc_pkg::RANGE_DIV40: quot = {1'b0, stc_pkg::div5(11'(mag >> 3))};
         stc_pkg::RANGE_DIV20: quot = {1'b0, stc_pkg::div5(11'(mag >> 2))};
         stc_pkg::RANGE_DIV8:  quot = 12'(mag >> 3);
         stc_pkg::RANGE_DIV4:  quot = 12'(mag >> 2);
         default:              quot = 12'(mag >> 1);
      endcase
   end

   assign quot_s   = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
   assign value    = quot_s + 13'sd30;
   assign value_cl = (value >= 13'sd240) ? 13'sd240 : value;
   assign value_inv = invert ? (13'sd240 - value_cl) : value_cl;

   always_comb begin
      if (value_inv > 13'sd1023) begin
         value_sat = 13'sd1023;
      end else if (value_inv < -13'sd1024) begin
         value_sat = -13'sd1024;
      end else begin
         value_sat = value_inv;
      end
   end

   assign trace = value_sat[10:0];

endmodule

### design/stc_trigger.sv
// ----------------------------------------------------------------------------
// stc_trigger
// Arm, edge search and capture sequencing on the trigger channel.
// ----------------------------------------------------------------------------
module stc_trigger #(
   parameter int CAPTURE_LENGTH = 320
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic signed [10:0]     trig_value,
   input  stc_pkg::trig_cfg_type  cfg,
   output stc_pkg::trig_out_type  status,
   output logic [8:0]             sample_index
);

   localparam int POS_W = $clog2(CAPTURE_LENGTH);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(CAPTURE_LENGTH - 1);

   stc_pkg::phase_type phase_ff, phase_in;
   logic signed [10:0] prev_ff, prev_in;
   logic [15:0]        count_ff, count_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               forced_ff, forced_in;

   logic               edge_hit;
   logic [15:0]        count_inc;
   logic               timeout_hit;
   logic               pos_last;
   logic signed [11:0] tv_x;
   logic signed [11:0] lv_x;
   logic signed [11:0] prev_x;

   assign tv_x   = {trig_value[10], trig_value};
   assign prev_x = {prev_ff[10], prev_ff};
   assign lv_x   = $signed({4'b0000, cfg.level});

   assign edge_hit = cfg.falling ? ((tv_x <= lv_x) && (tv_x < prev_x))
                                 : ((tv_x >= lv_x) && (tv_x > prev_x));
   assign count_inc   = (count_ff == 16'hFFFF) ? count_ff : count_ff + 16'd1;
   assign timeout_hit = (cfg.mode == stc_pkg::MODE_SCAN) ||
                        ((cfg.mode == stc_pkg::MODE_AUTO) && (count_inc >= cfg.timeout));
   assign pos_last    = (pos_ff == POS_LAST);

   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         unique case (phase_ff)
            stc_pkg::PH_SEARCH: begin
               if (edge_hit || timeout_hit) begin
                  phase_in = stc_pkg::PH_CAPTURE;
               end
            end
            stc_pkg::PH_CAPTURE: begin
               if (pos_last) begin
                  phase_in = stc_pkg::PH_ARM;
               end
            end
            default: begin
               phase_in = (cfg.mode == stc_pkg::MODE_SCAN) ? stc_pkg::PH_CAPTURE
                                                           : stc_pkg::PH_SEARCH;
            end
         endcase
      end
   end

   always_comb begin
      prev_in      = prev_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      forced_in    = forced_ff;
      status       = '0;
      sample_index = 9'(pos_ff);
      unique case (phase_ff)
         stc_pkg::PH_SEARCH: begin
            if (edge_hit) begin
               pos_in    = '0;
               forced_in = 1'b0;
            end else begin
               prev_in  = trig_value;
               count_in = count_inc;
               if (timeout_hit) begin
                  pos_in    = '0;
                  forced_in = 1'b1;
               end
            end
         end
         stc_pkg::PH_CAPTURE: begin
            status.emit   = 1'b1;
            status.last   = pos_last;
            status.forced = forced_ff;
            pos_in        = pos_last ? '0 : pos_ff + 1'b1;
         end
         default: begin
            if (cfg.mode == stc_pkg::MODE_SCAN) begin
               status.emit   = 1'b1;
               status.last   = 1'b0;
               status.forced = 1'b1;
               sample_index  = '0;
               forced_in     = 1'b1;
               pos_in        = POS_W'(1);
            end else begin
               prev_in  = trig_value;
               count_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= stc_pkg::PH_ARM;
         prev_ff   <= '0;
         count_ff  <= '0;
         pos_ff    <= '0;
         forced_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (advance) begin
            prev_ff   <= prev_in;
            count_ff  <= count_in;
            pos_ff    <= pos_in;
            forced_ff <= forced_in;
         end
      end
   end

endmodule

### design/scope_trigger_capture.sv
// ----------------------------------------------------------------------------
// scope_trigger_capture
// Two-channel sample scaling with edge trigger and fixed-length capture.
// ----------------------------------------------------------------------------
//  port group   direction  handshake           payload
//  req_         in         req_valid/req_ready raw_ch0, raw_ch1
//  rsp_         out        rsp_valid/rsp_ready trace_ch0/1, index, last, forced
//  csr_         in         csr_write_en        csr_index, csr_write_data
//
//  One pair per cycle unless the result stalls: input register, scaling and
//  trigger logic, result reg. Arm pairs outside scan mode and search pairs
//  give no result. Reset clears the trigger sequencer, valid flags and
//  control registers to their defaults. A stalled result holds the input
//  register, which stalls the request side only when it cannot drain.
// ----------------------------------------------------------------------------
module scope_trigger_capture #(
   parameter int CAPTURE_LENGTH = 320
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [11:0]        req_raw_ch0,
   input  logic [11:0]        req_raw_ch1,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [10:0] rsp_trace_ch0,
   output logic signed [10:0] rsp_trace_ch1,
   output logic [8:0]         rsp_sample_index,
   output logic               rsp_last_sample,
   output logic               rsp_forced_trigger,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   logic [2:0]         range_ch0_ff, range_ch1_ff;
   logic signed [11:0] offset_ch0_ff, offset_ch1_ff;
   logic [1:0]         invert_ff;
   logic [7:0]         level_ff;
   logic [3:0]         control_ff;
   logic [15:0]        timeout_ff;

   logic               in_valid_ff;
   logic [11:0]        raw0_ff, raw1_ff;
   logic               advance;

   logic signed [10:0] trace0, trace1;
   logic signed [10:0] trig_value;
   stc_pkg::trig_cfg_type cfg;
   stc_pkg::trig_out_type status;
   logic [8:0]         index;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [10:0] trace0_ff, trace1_ff;
   logic [8:0]         index_ff;
   logic               last_ff, forced_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ch0_ff  <= '0;
         range_ch1_ff  <= '0;
         offset_ch0_ff <= '0;
         offset_ch1_ff <= '0;
         invert_ff     <= '0;
         level_ff      <= stc_pkg::LEVEL_RESET;
         control_ff    <= '0;
         timeout_ff    <= stc_pkg::TIMEOUT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            stc_pkg::CSR_RANGE_CH0:       range_ch0_ff  <= csr_write_data[2:0];
            stc_pkg::CSR_RANGE_CH1:       range_ch1_ff  <= csr_write_data[2:0];
            stc_pkg::CSR_OFFSET_CH0:      offset_ch0_ff <= csr_write_data[11:0];
            stc_pkg::CSR_OFFSET_CH1:      offset_ch1_ff <= csr_write_data[11:0];
            stc_pkg::CSR_INVERT_MASK:     invert_ff     <= csr_write_data[1:0];
            stc_pkg::CSR_TRIGGER_LEVEL:   level_ff      <= csr_write_data[7:0];
            stc_pkg::CSR_TRIGGER_CONTROL: control_ff    <= csr_write_data[3:0];
            stc_pkg::CSR_AUTO_TIMEOUT:    timeout_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // drain the input register when the result slot is free or being taken
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         raw0_ff <= req_raw_ch0;
         raw1_ff <= req_raw_ch1;
      end
   end

   stc_scale u_scale0 (
      .raw    (raw0_ff),
      .offset (offset_ch0_ff),
      .range  (range_ch0_ff),
      .invert (invert_ff[0]),
      .trace  (trace0)
   );

   stc_scale u_scale1 (
      .raw    (raw1_ff),
      .offset (offset_ch1_ff),
      .range  (range_ch1_ff),
      .invert (invert_ff[1]),
      .trace  (trace1)
   );

   assign trig_value  = control_ff[3] ? trace1 : trace0;
   assign cfg.mode    = control_ff[1:0];
   assign cfg.falling = control_ff[2];
   assign cfg.level   = level_ff;
   assign cfg.timeout = timeout_ff;

   stc_trigger #(
      .CAPTURE_LENGTH (CAPTURE_LENGTH)
   ) u_trigger (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .trig_value   (trig_value),
      .cfg          (cfg),
      .status       (status),
      .sample_index (index)
   );

   always_comb begin
      if (advance) begin
         rsp_valid_in = status.emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && status.emit) begin
         trace0_ff <= trace0;
         trace1_ff <= trace1;
         index_ff  <= index;
         last_ff   <= status.last;
         forced_ff <= status.forced;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_trace_ch0      = trace0_ff;
   assign rsp_trace_ch1      = trace1_ff;
   assign rsp_sample_index   = index_ff;
   assign rsp_last_sample    = last_ff;
   assign rsp_forced_trigger = forced_ff;

endmodule
